// ===== hdl/tbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-band biquad crossover package
// Widths, term codes, command bundle and saturation helpers shared by the
// crossover controller, datapath and channel interfaces.
// ----------------------------------------------------------------------------
package tbbc_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 30;
   localparam int ACC_BITS       = 2 * COEF_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int TAP_BITS       = 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic [2:0]                    term_type;
   typedef logic [CSR_INDEX_BITS-1:0]     csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_FEED0 = 2'd0;
   localparam csr_index_type CSR_FEED1 = 2'd1;
   localparam csr_index_type CSR_BACK1 = 2'd2;
   localparam csr_index_type CSR_BACK2 = 2'd3;

   // Product terms of one biquad stage, in issue order.
   localparam term_type TERM_X0 = 3'd0;
   localparam term_type TERM_X1 = 3'd1;
   localparam term_type TERM_X2 = 3'd2;
   localparam term_type TERM_Y1 = 3'd3;
   localparam term_type TERM_Y2 = 3'd4;

   // Last tap of a stage: the multiply of the last term has been issued and
   // only its accumulate remains.
   localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(5);

   localparam acc_type ROUND_CONST = acc_type'(64'sd1 <<< (COEF_FRAC_BITS - 1));

   localparam acc_type STAGE_MAX = acc_type'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
   localparam acc_type STAGE_MIN = acc_type'(-(64'sd1 <<< (COEF_BITS - 1)));

   localparam logic signed [COEF_BITS:0] BAND_MAX =
      (COEF_BITS+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [COEF_BITS:0] BAND_MIN =
      (COEF_BITS+1)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      logic     start;     // latch the sample and preload the accumulator
      logic     stage;     // 0 for stage one, 1 for stage two
      logic     mul_en;    // register the product of mul_term
      term_type mul_term;
      logic     acc_en;    // fold the registered product into the sum
      term_type acc_term;
      logic     finish;    // round, clip, and shift the stage delays
      logic     load_out;  // load the band results into the output register
   } cmd_type;

   function automatic coef_type sat_stage(input acc_type v);
      coef_type r;
      if (v > STAGE_MAX) begin
         r = STAGE_MAX[COEF_BITS-1:0];
      end else if (v < STAGE_MIN) begin
         r = STAGE_MIN[COEF_BITS-1:0];
      end else begin
         r = v[COEF_BITS-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_band(input logic signed [COEF_BITS:0] v);
      sample_type r;
      if (v > BAND_MAX) begin
         r = BAND_MAX[SAMPLE_BITS-1:0];
      end else if (v < BAND_MIN) begin
         r = BAND_MIN[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/tbbc_channels.sv =====
// ----------------------------------------------------------------------------
// Crossover channel interfaces
// Valid/ready channels for the sample requests and the band responses.
// ----------------------------------------------------------------------------
interface tbbc_req_if;
   import tbbc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface tbbc_rsp_if;
   import tbbc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type low_band;
   sample_type high_band;

   modport source (output valid, output low_band, output high_band, input ready);
   modport sink   (input valid, input low_band, input high_band, output ready);
endinterface

// ===== hdl/tbbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Crossover controller
// Sequences the shared multiplier over both biquad stages and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module tbbc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tbbc_pkg::cmd_type cmd
);
   import tbbc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [TAP_BITS-1:0] tap_ff, tap_in;
   logic                stage_ff, stage_in;
   logic                out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      stage_in     = stage_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      cmd.stage    = stage_ff;
      cmd.mul_term = term_type'(tap_ff);
      cmd.acc_term = term_type'(tap_ff - TAP_BITS'(1));
      req_ready    = 1'b0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               tap_in    = '0;
               stage_in  = 1'b0;
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mul_en = (tap_ff != LAST_TAP);
            cmd.acc_en = (tap_ff != '0);
            tap_in     = tap_ff + TAP_BITS'(1);
            if (tap_ff == LAST_TAP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            tap_in     = '0;
            if (stage_ff) begin
               state_in = ST_OUT;
            end else begin
               stage_in = 1'b1;
               state_in = ST_MAC;
            end
         end
         ST_OUT: begin
            // Wait until the output register is free or being emptied.
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         stage_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         stage_ff     <= stage_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== hdl/tbbc_datapath.sv =====
// ----------------------------------------------------------------------------
// Crossover datapath
// Coefficient registers, per-stage delay lines, one shared 32x32 multiplier,
// a 64-bit accumulator and the band output register.
// ----------------------------------------------------------------------------
module tbbc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  tbbc_pkg::cmd_type       cmd,
   input  tbbc_pkg::sample_type    sample_in,
   input  logic                    csr_we,
   input  tbbc_pkg::csr_index_type csr_index,
   input  tbbc_pkg::coef_type      csr_wdata,
   output tbbc_pkg::sample_type    low_band,
   output tbbc_pkg::sample_type    high_band
);
   import tbbc_pkg::*;

   coef_type   feed0_ff, feed1_ff, back1_ff, back2_ff;
   sample_type sample_ff;
   sample_type s1_xd_ff [2];
   coef_type   s1_yd_ff [2];
   coef_type   s2_xd_ff [2];
   coef_type   s2_yd_ff [2];
   acc_type    prod_ff, prod_in;
   acc_type    acc_ff, acc_in;
   sample_type low_ff, high_ff;

   coef_type   mul_coef, mul_data;
   coef_type   stage_y;
   acc_type    acc_shifted;
   logic signed [COEF_BITS:0] s2_wide, x_wide;

   function automatic coef_type widen(input sample_type s);
      return {{(COEF_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_term)
         TERM_X0: begin
            mul_coef = feed0_ff;
            mul_data = cmd.stage ? s1_yd_ff[0] : widen(sample_ff);
         end
         TERM_X1: begin
            mul_coef = feed1_ff;
            mul_data = cmd.stage ? s2_xd_ff[0] : widen(s1_xd_ff[0]);
         end
         TERM_X2: begin
            mul_coef = feed0_ff;
            mul_data = cmd.stage ? s2_xd_ff[1] : widen(s1_xd_ff[1]);
         end
         TERM_Y1: begin
            mul_coef = back1_ff;
            mul_data = cmd.stage ? s2_yd_ff[0] : s1_yd_ff[0];
         end
         TERM_Y2: begin
            mul_coef = back2_ff;
            mul_data = cmd.stage ? s2_yd_ff[1] : s1_yd_ff[1];
         end
         default: begin
            mul_coef = '0;
            mul_data = '0;
         end
      endcase
   end

   assign prod_in = acc_type'(mul_coef) * acc_type'(mul_data);

   // Feedback terms are subtracted; the sum wraps modulo 2^64.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start || cmd.finish) begin
         acc_in = ROUND_CONST;
      end else if (cmd.acc_en) begin
         if (cmd.acc_term == TERM_Y1 || cmd.acc_term == TERM_Y2) begin
            acc_in = acc_ff - prod_ff;
         end else begin
            acc_in = acc_ff + prod_ff;
         end
      end
   end

   assign acc_shifted = acc_ff >>> COEF_FRAC_BITS;
   assign stage_y     = sat_stage(acc_shifted);

   assign s2_wide = {s2_yd_ff[0][COEF_BITS-1], s2_yd_ff[0]};
   assign x_wide  = {{(COEF_BITS+1-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.start) begin
         sample_ff <= sample_in;
      end
      if (cmd.load_out) begin
         low_ff  <= sat_band(s2_wide);
         high_ff <= sat_band(x_wide - s2_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed0_ff <= '0;
         feed1_ff <= '0;
         back1_ff <= '0;
         back2_ff <= '0;
         s1_xd_ff <= '{default: '0};
         s1_yd_ff <= '{default: '0};
         s2_xd_ff <= '{default: '0};
         s2_yd_ff <= '{default: '0};
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FEED0: feed0_ff <= csr_wdata;
               CSR_FEED1: feed1_ff <= csr_wdata;
               CSR_BACK1: back1_ff <= csr_wdata;
               CSR_BACK2: back2_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.finish) begin
            if (cmd.stage) begin
               s2_xd_ff[1] <= s2_xd_ff[0];
               s2_xd_ff[0] <= s1_yd_ff[0];
               s2_yd_ff[1] <= s2_yd_ff[0];
               s2_yd_ff[0] <= stage_y;
            end else begin
               s1_xd_ff[1] <= s1_xd_ff[0];
               s1_xd_ff[0] <= sample_ff;
               s1_yd_ff[1] <= s1_yd_ff[0];
               s1_yd_ff[0] <= stage_y;
            end
         end
      end
   end

   assign low_band  = low_ff;
   assign high_band = high_ff;

endmodule

// ===== hdl/two_band_biquad_crossover_unit.sv =====
// ----------------------------------------------------------------------------
// Two-band biquad crossover unit
// Fourth-order low band from two cascaded direct-form-I biquads, plus the
// complementary high band (input minus the stage-two output before the band clip).
// ----------------------------------------------------------------------------
// Usage:
// A sample word arrives on req_chan and is taken when valid and ready are
// both high. Ready is high only while the unit is idle. The sample runs
// through stage one and then stage two on one shared 32x32 multiplier: each
// stage issues its five multiplies, drains the last accumulate and then
// rounds and clips. The response word (low band, high band) is then loaded
// into the output register before the unit takes the next sample.
// The output register separates the two sides: a new sample is accepted
// while the previous response still waits on rsp_chan. If that response is
// still unread when the next one is finished, the unit holds the new result
// until rsp_chan.ready rises. The user must see that coefficients are written
// through the csr_ port only while the unit is idle; the unit does not
// enforce this. Reset clears the coefficients, all stage delays and the
// response valid flag; the unit accepts a sample in the first cycle after.
// ----------------------------------------------------------------------------
module two_band_biquad_crossover_unit (
   input  logic                    clock,
   input  logic                    reset,
   tbbc_req_if.sink                req_chan,
   tbbc_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  tbbc_pkg::csr_index_type csr_index,
   input  tbbc_pkg::coef_type      csr_wdata
);
   import tbbc_pkg::*;

   cmd_type    cmd;
   logic       req_ready;
   logic       rsp_valid;
   sample_type low_band;
   sample_type high_band;

   // The controller decides when each multiply, accumulate and stage update
   // happens; the datapath only follows its commands.
   tbbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tbbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample_in (req_chan.sample_in),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .low_band  (low_band),
      .high_band (high_band)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.low_band  = low_band;
   assign rsp_chan.high_band = high_band;

   // The unit is busy right after it takes a sample.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("crossover accepted a sample while busy");

   // After a sample is taken, stage one's taps and finish and stage two's taps run before stage two finishes.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> ##14 cmd.finish && cmd.stage)
      else $error("stage two did not finish on schedule");

   // A new result never overwrites one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("unread response overwritten");

endmodule

// ===== tb/two_band_biquad_crossover_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-band biquad crossover unit testbench
// Feeds sample words through the crossover under a series of coefficient
// settings and checks every band word against an in-bench fixed-point model or its directed value.
// ----------------------------------------------------------------------------
module two_band_biquad_crossover_unit_tb;
   import tbbc_pkg::*;

   // Half of the 12 ns clock period.
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 10;

   // About 26 percent idle on each side.
   localparam int IDLE_PERCENT = 26;

   // Random part: twelve coefficient phases of 95 sample words each.
   localparam int PHASES = 12;
   localparam int WORDS_PER_PHASE = 95;

   // The sender offers every word back to back in this window of the random
   // part, and waits for every band word to come home at the pause index.
   localparam int STEADY_FIRST = 500;
   localparam int STEADY_LAST = 650;
   localparam int PAUSE_INDEX = 850;

   // The receiver holds off once, well inside a phase, long enough for the
   // output register and the pipeline to fill and the request side to stall.
   localparam int HOLD_TRIGGER = 360;
   localparam int HOLD_CYCLES = 300;
   localparam int STEADY_RSP_FIRST = 520;
   localparam int STEADY_RSP_LAST = 700;

   // The tail leaves room for a stray extra word to show up after the last
   // expected one.
   localparam int TAIL_CYCLES = 20;

   // The slowest correct stretch without any handshake is the receiver's long
   // hold-off plus one sample time. The limit is many times that.
   localparam int WATCHDOG_LIMIT = 4000;

   localparam int MAX_REPORTS = 10;

   localparam longint signed ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam longint signed SAMPLE_TOP = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint signed SAMPLE_BOT = -SAMPLE_TOP - 64'sd1;
   localparam coef_type COEF_TOP = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type COEF_BOT = {1'b1, {(COEF_BITS-1){1'b0}}};

   // 0.5 in the coefficient format, used to show the half-up rounding.
   localparam coef_type COEF_HALF = coef_type'(64'sd1 <<< (COEF_FRAC_BITS - 1));

   typedef struct {
      sample_type low;
      sample_type high;
   } band_pair_type;

   typedef enum bit {ROW_SAMPLE, ROW_COEF} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      coef_type      coef;
      sample_type    x;
      bit            typed;
      sample_type    low;
      sample_type    high;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   coef_type csr_wdata;

   tbbc_req_if req_chan ();
   tbbc_rsp_if rsp_chan ();

   two_band_biquad_crossover_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Bench copy of the coefficients and of the delay lines of both stages.
   // Index 0 of the stage dimension is stage one, index 1 is stage two.
   longint signed k_feed0 = 0;
   longint signed k_feed1 = 0;
   longint signed k_back1 = 0;
   longint signed k_back2 = 0;
   longint signed dly_x[2][2];
   longint signed dly_y[2][2];

   band_pair_type band_queue[$];
   dir_row_type dir_rows[$];

   int words_checked = 0;
   int words_sent = 0;
   int mismatches = 0;
   int coef_settings = 0;
   int quiet_cycles = 0;

   function automatic longint signed clip_to(input longint signed v, input int bits);
      longint signed hi;
      longint signed lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // One direct-form-I biquad step. The sum wraps at 64 bits the way a
   // hardware accumulator of that width does; the shift is arithmetic, so the
   // added half rounds toward plus infinity.
   function automatic longint signed run_biquad(input int st, input longint signed x0);
      longint signed acc;
      longint signed y;
      acc = k_feed0 * x0 + k_feed1 * dly_x[st][0] + k_feed0 * dly_x[st][1]
            - k_back1 * dly_y[st][0] - k_back2 * dly_y[st][1] + ROUND_HALF;
      y = clip_to(acc >>> COEF_FRAC_BITS, COEF_BITS);
      dly_x[st][1] = dly_x[st][0];
      dly_x[st][0] = x0;
      dly_y[st][1] = dly_y[st][0];
      dly_y[st][0] = y;
      return y;
   endfunction

   // The high band is taken from the stage-two output before its band clip, so a
   // low band that saturates does not leak into the high band.
   function automatic void crossover_predict(input sample_type x,
                                             output sample_type lo,
                                             output sample_type hi);
      longint signed xs;
      longint signed s1;
      longint signed s2;
      xs = x;
      s1 = run_biquad(0, xs);
      s2 = run_biquad(1, s1);
      lo = sample_type'(clip_to(s2, SAMPLE_BITS));
      hi = sample_type'(clip_to(xs - s2, SAMPLE_BITS));
   endfunction

   function automatic void apply_coef(input csr_index_type idx, input coef_type v);
      case (idx)
         CSR_FEED0: k_feed0 = v;
         CSR_FEED1: k_feed1 = v;
         CSR_BACK1: k_back1 = v;
         CSR_BACK2: k_back2 = v;
         default: ;
      endcase
   endfunction

   function automatic sample_type pick_sample();
      sample_type s;
      case ($urandom_range(9))
         5: begin
            // Corners of the sample range.
            case ($urandom_range(3))
               0: s = sample_type'(SAMPLE_TOP);
               1: s = sample_type'(SAMPLE_BOT);
               2: s = '0;
               default: s = '1;
            endcase
         end
         6: s = sample_type'(int'($urandom_range(510)) - 255);
         7, 8: s = sample_type'($signed($urandom) >>> 11);
         default: s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   task automatic add_sample(input sample_type x, input bit typed,
                             input sample_type lo, input sample_type hi);
      dir_row_type r;
      r.kind = ROW_SAMPLE;
      r.idx = CSR_FEED0;
      r.coef = '0;
      r.x = x;
      r.typed = typed;
      r.low = lo;
      r.high = hi;
      dir_rows.push_back(r);
   endtask

   task automatic add_coef(input csr_index_type idx, input coef_type v);
      dir_row_type r;
      r.kind = ROW_COEF;
      r.idx = idx;
      r.coef = v;
      r.x = '0;
      r.typed = 1'b0;
      r.low = '0;
      r.high = '0;
      dir_rows.push_back(r);
   endtask

   // Offers one sample word and returns at the edge that takes it. The bench
   // model advances at that same edge. A typed row supplies its own expected
   // bands; the model still runs so that its delay lines stay in step.
   task automatic push_word(input sample_type x, input bit typed,
                            input sample_type lo, input sample_type hi);
      sample_type plo;
      sample_type phi;
      band_pair_type want;
      req_chan.valid <= 1'b1;
      req_chan.sample_in <= x;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      crossover_predict(x, plo, phi);
      want.low = typed ? lo : plo;
      want.high = typed ? hi : phi;
      band_queue.push_back(want);
      words_sent++;
   endtask

   // Random idle cycles on the request side. Valid is lowered only when an
   // idle cycle actually follows, so it never drops and rises in one step.
   task automatic idle_gap();
      while ($urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every band word in flight has arrived.
   // Every sample yields exactly one band word, so the unit is idle then.
   task automatic drain_bands();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (band_queue.size() != 0);
   endtask

   // Writes one coefficient. Back-to-back writes keep the enable high; the
   // last write of a group lowers it.
   task automatic write_coef(input csr_index_type idx, input coef_type v, input bit last);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      apply_coef(idx, v);
      if (last) begin
         csr_we <= 1'b0;
      end
   endtask

   // Response side: random readiness, one long hold-off that backs the unit
   // up, and a window with the receiver always ready.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (!hold_done && words_checked >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (words_checked >= STEADY_RSP_FIRST && words_checked < STEADY_RSP_LAST) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               rsp_chan.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
            @(posedge clock);
         end
      end
   end

   // Every band word that the unit hands over is matched against the oldest
   // expected pair.
   always @(posedge clock) begin
      band_pair_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         words_checked++;
         if (band_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("band word %0d arrived with none expected: low %0d high %0d",
                        words_checked, rsp_chan.low_band, rsp_chan.high_band);
            end
         end else begin
            want = band_queue.pop_front();
            if (want.low !== rsp_chan.low_band || want.high !== rsp_chan.high_band) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("band word %0d: expected low %0d high %0d, got low %0d high %0d",
                           words_checked, want.low, want.high,
                           rsp_chan.low_band, rsp_chan.high_band);
               end
            end
         end
      end
   end

   // Watchdog on handshakes: any accepted word or register write restarts it.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d band words still expected",
                     quiet_cycles, band_queue.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int n;
      coef_type f0;
      coef_type f1;
      coef_type b1;
      coef_type b2;

      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < 2; k++) begin
            dly_x[s][k] = 0;
            dly_y[s][k] = 0;
         end
      end

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample_in <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_FEED0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With the coefficients cleared by reset the low band is
      // zero and the high band is the sample itself, so those rows carry their
      // expected words. Half a unit in feed0 shows the half-up rounding on
      // odd samples of both signs. The extreme coefficients make an unstable
      // filter: the stage outputs pin at the 32-bit rails, the stage-two sum
      // wraps in the accumulator, and both bands clip. Clearing the
      // coefficients again brings back the plain pass-through of the input.
      add_sample(sample_type'(SAMPLE_TOP), 1'b1, '0, sample_type'(SAMPLE_TOP));
      add_sample(sample_type'(SAMPLE_BOT), 1'b1, '0, sample_type'(SAMPLE_BOT));
      add_sample('0, 1'b1, '0, '0);
      add_sample('1, 1'b1, '0, '1);
      add_sample(sample_type'(1), 1'b1, '0, sample_type'(1));
      add_coef(CSR_FEED0, COEF_HALF);
      add_coef(CSR_FEED1, '0);
      add_coef(CSR_BACK1, '0);
      add_coef(CSR_BACK2, '0);
      add_sample(sample_type'(1), 1'b0, '0, '0);
      add_sample('1, 1'b0, '0, '0);
      add_sample(sample_type'(3), 1'b0, '0, '0);
      add_sample(sample_type'(-3), 1'b0, '0, '0);
      add_sample('0, 1'b0, '0, '0);
      add_sample('0, 1'b0, '0, '0);
      add_coef(CSR_FEED0, COEF_TOP);
      add_coef(CSR_FEED1, COEF_BOT);
      add_coef(CSR_BACK1, COEF_BOT);
      add_coef(CSR_BACK2, COEF_TOP);
      add_sample(sample_type'(SAMPLE_TOP), 1'b0, '0, '0);
      add_sample(sample_type'(SAMPLE_BOT), 1'b0, '0, '0);
      add_sample(sample_type'(SAMPLE_TOP), 1'b0, '0, '0);
      add_sample(sample_type'(SAMPLE_BOT), 1'b0, '0, '0);
      add_sample(sample_type'(SAMPLE_TOP), 1'b0, '0, '0);
      add_sample('0, 1'b0, '0, '0);
      add_coef(CSR_FEED0, '0);
      add_coef(CSR_FEED1, '0);
      add_coef(CSR_BACK1, '0);
      add_coef(CSR_BACK2, '0);
      add_sample(sample_type'(SAMPLE_TOP), 1'b1, '0, sample_type'(SAMPLE_TOP));
      add_sample(sample_type'(SAMPLE_BOT), 1'b1, '0, sample_type'(SAMPLE_BOT));

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].kind == ROW_COEF) begin
            // Coefficients change only with the unit idle.
            if (i == 0 || dir_rows[i-1].kind != ROW_COEF) begin
               drain_bands();
               coef_settings++;
            end
            write_coef(dir_rows[i].idx, dir_rows[i].coef,
                       (i + 1 == dir_rows.size()) || dir_rows[i+1].kind != ROW_COEF);
         end else begin
            push_word(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].low, dir_rows[i].high);
            idle_gap();
         end
      end

      // Random part. Each phase loads a new coefficient set: two real
      // Butterworth low-pass designs (1 kHz and 4 kHz at 48 kHz), random
      // words over the full range, random words within about half a unit,
      // and all four registers at the top and at the bottom of their range.
      // The delay lines carry over from one phase into the next.
      n = 0;
      for (int p = 0; p < PHASES; p++) begin
         case (p % 6)
            0: begin
               f0 = coef_type'(4204900);
               f1 = coef_type'(8409800);
               b1 = coef_type'(-1949201113);
               b2 = coef_type'(892279456);
            end
            1: begin
               f0 = coef_type'($urandom);
               f1 = coef_type'($urandom);
               b1 = coef_type'($urandom);
               b2 = coef_type'($urandom);
            end
            2: begin
               f0 = coef_type'(53139483);
               f1 = coef_type'(106278966);
               b1 = coef_type'(-1373994398);
               b2 = coef_type'(512810500);
            end
            3: begin
               f0 = COEF_TOP;
               f1 = COEF_TOP;
               b1 = COEF_TOP;
               b2 = COEF_TOP;
            end
            4: begin
               f0 = coef_type'($signed($urandom) >>> 2);
               f1 = coef_type'($signed($urandom) >>> 2);
               b1 = coef_type'($signed($urandom) >>> 2);
               b2 = coef_type'($signed($urandom) >>> 2);
            end
            default: begin
               f0 = COEF_BOT;
               f1 = COEF_BOT;
               b1 = COEF_BOT;
               b2 = COEF_BOT;
            end
         endcase
         drain_bands();
         write_coef(CSR_FEED0, f0, 1'b0);
         write_coef(CSR_FEED1, f1, 1'b0);
         write_coef(CSR_BACK1, b1, 1'b0);
         write_coef(CSR_BACK2, b2, 1'b1);
         coef_settings++;

         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            push_word(pick_sample(), 1'b0, '0, '0);
            if (n < STEADY_FIRST || n >= STEADY_LAST) begin
               idle_gap();
            end
            if (n == PAUSE_INDEX) begin
               drain_bands();
            end
            n++;
         end
      end

      drain_bands();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("crossover run: %0d sample words sent, %0d band words checked, %0d coefficient sets",
               words_sent, words_checked, coef_settings);
      $display("mismatching or unexpected band words: %0d, band words never delivered: %0d",
               mismatches, band_queue.size());
      if (mismatches == 0 && band_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
